// File: rtl/aes_block_encrypt_decrypt_assert.svh
// Assertion macros shared by the AES block RTL.
// Included by modules that carry concurrent assertions.
`ifndef AES_BLOCK_ENCRYPT_DECRYPT_ASSERT_SVH
`define AES_BLOCK_ENCRYPT_DECRYPT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define AES_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define AES_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// File: rtl/aes_pkg.sv
// Package for the AES block: constants, state type and byte-level functions.
// No dependencies.
`default_nettype none
package aes_pkg;
    localparam int KEY_WORDS   = 4;
    localparam int ROUNDS      = 10;
    localparam int STORE_WORDS = 4 * (ROUNDS + 1);
    localparam int RKA_W       = $clog2(STORE_WORDS);
    localparam int RND_W       = $clog2(ROUNDS + 1);

    localparam logic [1:0] CFG_KEY0 = 2'd0;
    localparam logic [1:0] CFG_KEY1 = 2'd1;
    localparam logic [1:0] CFG_KEY2 = 2'd2;
    localparam logic [1:0] CFG_KEY3 = 2'd3;
    localparam int CFG_IDX_W = 2;
    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    typedef enum logic [2:0] {
        ST_EXPAND, ST_IDLE, ST_LOAD, ST_RUN, ST_DONE
    } t_state;

    typedef struct packed {
        logic               start;
        logic               decrypt;
        logic               first;
        logic               last;
    } t_round_ctl;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = xtime(x);
        end
        gmul = p;
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        sbox = t[x];
    endfunction

    // Inverse S-box, searched from the forward table as a constant mapping.
    function automatic logic [7:0] inv_sbox(input logic [7:0] y);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 256; i++) begin
            if (sbox(8'(i)) == y) r = 8'(i);
        end
        inv_sbox = r;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction
endpackage
`default_nettype wire

// File: rtl/aes_key_exp.sv
// Key expansion sequencer and round-key store (one word per cycle).
// Depends on aes_pkg.
`default_nettype none
module aes_key_exp import aes_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [255:0]         i_key,
    input  wire logic [RND_W-1:0]     i_rd_round,
    output logic      [127:0]         o_rd_key,
    output logic                      o_busy
);
    logic [31:0]      r_win [KEY_WORDS];
    logic [RKA_W-1:0] r_idx;
    logic [RKA_W-1:0] r_mod;
    logic [7:0]       r_rcon;
    logic             r_busy;
    logic [31:0]      n_word;
    logic [31:0]      w_t;
    logic [31:0]      w_kw;

    always_comb begin
        w_kw = i_key[255 - 32 * int'(r_idx[2:0]) -: 32];
        w_t  = r_win[KEY_WORDS-1];
        if (r_mod == '0)
            w_t = sub_word({w_t[23:0], w_t[31:24]}) ^ {r_rcon, 24'h0};
        else if (KEY_WORDS > 6 && r_mod == RKA_W'(4))
            w_t = sub_word(w_t);
        n_word = (r_idx < RKA_W'(KEY_WORDS)) ? w_kw : (r_win[0] ^ w_t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_mod  <= '0;
            r_rcon <= 8'h01;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_mod  <= '0;
            r_rcon <= 8'h01;
        end else if (r_busy) begin
            r_idx <= r_idx + 1'b1;
            r_mod <= (r_mod == RKA_W'(KEY_WORDS - 1)) ? '0 : r_mod + 1'b1;
            if (r_idx >= RKA_W'(KEY_WORDS) && r_mod == '0) r_rcon <= xtime(r_rcon);
            if (r_idx == RKA_W'(STORE_WORDS - 1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            for (int k = 0; k < KEY_WORDS - 1; k++) r_win[k] <= r_win[k+1];
            r_win[KEY_WORDS-1] <= n_word;
        end
    end

    // The store is split into four column banks of ROUNDS + 1 words, so one
    // round key set is a single registered read from each bank.
    for (genvar c = 0; c < 4; c++) begin : g_bank
        logic [31:0] r_mem [ROUNDS + 1];
        logic [31:0] r_q;
        always_ff @(posedge i_clk) begin
            if (r_busy && r_idx[1:0] == 2'(c)) r_mem[r_idx[RKA_W-1:2]] <= n_word;
            r_q <= r_mem[i_rd_round];
        end
    end

    assign o_rd_key = {g_bank[0].r_q, g_bank[1].r_q, g_bank[2].r_q, g_bank[3].r_q};
    assign o_busy   = r_busy;
endmodule
`default_nettype wire

// File: rtl/aes_round.sv
// Shared round unit: one encrypt or decrypt round per cycle on the state register.
// Depends on aes_pkg.
`default_nettype none
module aes_round import aes_pkg::*; (
    input  wire logic         i_clk,
    input  wire t_round_ctl   i_ctl,
    input  wire logic [127:0] i_block,
    input  wire logic [127:0] i_key,
    output logic      [127:0] o_state
);
    logic [127:0] r_state;
    logic [7:0]   w_s [16];
    logic [7:0]   w_a [16];
    logic [7:0]   w_b [16];
    logic [7:0]   w_m [16];
    logic [127:0] w_k;
    logic [127:0] n_state;

    always_comb begin
        for (int i = 0; i < 16; i++) w_s[i] = r_state[127 - 8*i -: 8];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) begin
                if (!i_ctl.decrypt)
                    w_a[r + 4*c] = sbox(w_s[r + 4*((c + r) & 3)]);
                else
                    w_a[r + 4*((c + r) & 3)] = inv_sbox(w_s[r + 4*c]);
            end
        for (int i = 0; i < 16; i++) w_b[i] = w_a[i] ^ i_key[127 - 8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                w_m[r + 4*c] = 8'h00;
                for (int k = 0; k < 4; k++) begin
                    logic [7:0] src;
                    src = i_ctl.decrypt ? w_b[k + 4*c] : w_a[k + 4*c];
                    case ((k + 4 - r) & 3)
                        0: w_m[r+4*c] ^= gmul(src, i_ctl.decrypt ? 8'h0e : 8'h02);
                        1: w_m[r+4*c] ^= gmul(src, i_ctl.decrypt ? 8'h0b : 8'h03);
                        2: w_m[r+4*c] ^= gmul(src, i_ctl.decrypt ? 8'h0d : 8'h01);
                        default: w_m[r+4*c] ^= gmul(src, i_ctl.decrypt ? 8'h09 : 8'h01);
                    endcase
                end
            end
        for (int i = 0; i < 16; i++) begin
            if (i_ctl.last) n_state[127 - 8*i -: 8] = w_b[i];
            else if (i_ctl.decrypt) n_state[127 - 8*i -: 8] = w_m[i];
            else n_state[127 - 8*i -: 8] = w_m[i] ^ i_key[127 - 8*i -: 8];
        end
        w_k = i_key;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.first) r_state <= i_block ^ w_k;
        else if (i_ctl.start) r_state <= n_state;
    end

    assign o_state = r_state;
endmodule
`default_nettype wire

// File: rtl/aes_block_encrypt_decrypt.sv
// AES block cipher top level: config, sequencer, key store and round unit.
// Depends on aes_pkg, aes_key_exp, aes_round and the assertion header.
//
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_ready         i_command, i_block_hi, i_block_lo
//  output    out        o_valid / i_ready         o_result_hi, o_result_lo
//  config    in         i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//
// A block runs from the input beat to the output beat as follows: the first
// round key is fetched at the input beat, the next cycle does the initial key
// addition, then one round per cycle through the shared round unit, which reads
// one round key set from the store. The unit is idle again in the cycle after the
// output beat, so the next input beat is taken only after the last block has left.
// After reset and after each key write while idle or expanding, the expander
// fills the store one word per cycle, and no input beat is taken until it is done.
// A stalled output beat holds the block; the next input beat waits for it.
`default_nettype none
`include "aes_block_encrypt_decrypt_assert.svh"
module aes_block_encrypt_decrypt import aes_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_command,
    input  wire logic [63:0]          i_block_hi,
    input  wire logic [63:0]          i_block_lo,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic      [63:0]          o_result_hi,
    output logic      [63:0]          o_result_lo,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]          i_cfg_data
);
    t_state           r_state, n_state;
    logic [255:0]     r_key;
    logic             r_kick;
    logic             r_dec;
    logic [127:0]     r_blk;
    logic [RND_W-1:0] r_rnd;
    logic [127:0]     w_rkey;
    logic [127:0]     w_out;
    logic             w_busy;
    t_round_ctl       w_ctl;
    logic [RND_W-1:0] w_rd_round;

    // Key registers; every valid write restarts the expansion.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_kick <= 1'b1;
        end else begin
            r_kick <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_KEY0: r_key[255:192] <= i_cfg_data;
                    CFG_KEY1: r_key[191:128] <= i_cfg_data;
                    CFG_KEY2: r_key[127:64]  <= i_cfg_data;
                    CFG_KEY3: r_key[63:0]    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    aes_key_exp u_key (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_kick),
        .i_key      (r_key),
        .i_rd_round (w_rd_round),
        .o_rd_key   (w_rkey),
        .o_busy     (w_busy)
    );

    // Round to fetch: the store read is registered, so address one round ahead.
    // While idle, the offered command picks the first key; the final round
    // fetches nothing new.
    always_comb begin
        w_rd_round = r_rnd;
        if (r_state == ST_IDLE)
            w_rd_round = i_command ? RND_W'(ROUNDS) : '0;
        else if ((r_state == ST_LOAD || r_state == ST_RUN) && !w_ctl.last)
            w_rd_round = r_dec ? r_rnd - 1'b1 : r_rnd + 1'b1;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_EXPAND: if (!w_busy && !r_kick) n_state = ST_IDLE;
            ST_IDLE:   if (r_kick) n_state = ST_EXPAND;
                       else if (i_valid) n_state = ST_LOAD;
            ST_LOAD:   n_state = ST_RUN;
            ST_RUN:    if (w_ctl.last) n_state = ST_DONE;
            ST_DONE:   if (i_ready) n_state = ST_IDLE;
            default:   n_state = ST_EXPAND;
        endcase
    end

    // In LOAD the fetched key is round 0 (or ROUNDS); in RUN r_rnd names the
    // round whose key arrives this cycle, and last marks the final round.
    always_comb begin
        w_ctl         = '0;
        w_ctl.decrypt = r_dec;
        w_ctl.first   = (r_state == ST_LOAD);
        w_ctl.start   = (r_state == ST_RUN);
        w_ctl.last    = (r_state == ST_RUN) &&
                        (r_dec ? (r_rnd == '0) : (r_rnd == RND_W'(ROUNDS)));
        o_ready       = (r_state == ST_IDLE) && !r_kick;
        o_valid       = (r_state == ST_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EXPAND;
            r_rnd   <= '0;
            r_dec   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && o_ready && i_valid) begin
                r_dec <= i_command;
                r_rnd <= i_command ? RND_W'(ROUNDS) : '0;
            end else if (r_state == ST_LOAD || (r_state == ST_RUN && !w_ctl.last)) begin
                r_rnd <= r_dec ? r_rnd - 1'b1 : r_rnd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_blk <= {i_block_hi, i_block_lo};
    end

    aes_round u_round (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_block (r_blk),
        .i_key   (w_rkey),
        .o_state (w_out)
    );

    assign o_result_hi = w_out[127:64];
    assign o_result_lo = w_out[63:0];

    `AES_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == ST_IDLE && !w_busy)
    `AES_ASSERT_IMP(a_excl, i_clk, i_rst_n, o_valid, !o_ready)
    `AES_ASSERT_NXT(a_accept, i_clk, i_rst_n, o_ready && i_valid, r_state == ST_LOAD)
    `AES_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(w_out))
endmodule
`default_nettype wire

// File: bench/aes_block_encrypt_decrypt_test.sv
// Self-checking testbench for the AES-128 block encrypt/decrypt unit.
// Depends on aes_pkg and the aes_block_encrypt_decrypt RTL; it predicts every block
// with its own cipher model and checks each output beat against it in order.
`timescale 1ns / 1ps
module aes_block_encrypt_decrypt_test;
    import aes_pkg::*;

    // One input beat: the command and the 128-bit block.
    typedef struct {
        logic        cmd;
        logic [63:0] hi;
        logic [63:0] lo;
    } cipher_job_t;

    // One expected output beat.
    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } cipher_text_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic                 i_command = CMD_ENC;
    logic [63:0]          i_block_hi = '0;
    logic [63:0]          i_block_lo = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [63:0]          o_result_hi;
    logic [63:0]          o_result_lo;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_KEY0;
    logic [63:0]          i_cfg_data = '0;

    // Stimulus and scoreboard state.
    cipher_job_t  job_queue[$];
    cipher_text_t cipher_expect_q[$];
    cipher_job_t  offered_job;
    int           error_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    logic         recv_hold = 1'b0;

    // Predictor state: the key registers, the expanded schedule and the S-boxes.
    logic [63:0] key_reg [4];
    logic [31:0] round_keys [STORE_WORDS];
    logic [7:0]  fwd_sub [256];
    logic [7:0]  inv_sub [256];

    aes_block_encrypt_decrypt DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_block_hi  (i_block_hi),
        .i_block_lo  (i_block_lo),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result_hi (o_result_hi),
        .o_result_lo (o_result_lo),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Multiplication in GF(2^8) modulo the AES polynomial.
    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    // Both S-boxes are derived from the field inverse plus the affine map.
    function automatic void build_sboxes();
        logic [7:0] inv_val;
        logic [7:0] base;
        logic [7:0] s;
        int         e;
        for (int x = 0; x < 256; x++) begin
            inv_val = 8'h01;
            base = 8'(x);
            e = 254;
            while (e != 0) begin
                if (e[0]) inv_val = gf_times(inv_val, base);
                base = gf_times(base, base);
                e >>= 1;
            end
            if (x == 0) inv_val = 8'h00;
            s = inv_val ^ {inv_val[6:0], inv_val[7]} ^ {inv_val[5:0], inv_val[7:6]}
                ^ {inv_val[4:0], inv_val[7:5]} ^ {inv_val[3:0], inv_val[7:4]} ^ 8'h63;
            fwd_sub[x] = s;
            inv_sub[s] = 8'(x);
        end
    endfunction

    function automatic logic [31:0] sub_word32(input logic [31:0] w);
        return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
    endfunction

    // Rebuilds the round-key schedule from the key registers.
    function automatic void expand_schedule();
        logic [7:0]  rcon;
        logic [31:0] t;
        rcon = 8'h01;
        for (int i = 0; i < STORE_WORDS; i++) begin
            if (i < KEY_WORDS) begin
                round_keys[i] = i[0] ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
            end else begin
                t = round_keys[i - 1];
                if (i % KEY_WORDS == 0) begin
                    t = sub_word32({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                    rcon = gf_times(rcon, 8'h02);
                end else if (KEY_WORDS > 6 && i % KEY_WORDS == 4) begin
                    t = sub_word32(t);
                end
                round_keys[i] = round_keys[i - KEY_WORDS] ^ t;
            end
        end
    endfunction

    // Works out the block the unit must return for one input beat.
    // State bytes are indexed row + 4 * column.
    function automatic cipher_text_t cipher_block(input cipher_job_t job);
        logic [7:0]   st [16];
        logic [7:0]   tmp [16];
        logic [7:0]   col [4];
        logic [7:0]   mat [4];
        logic [31:0]  w;
        int           rd;
        int           step;
        cipher_text_t res;
        for (int i = 0; i < 8; i++) begin
            st[i]     = job.hi[63 - 8 * i -: 8];
            st[i + 8] = job.lo[63 - 8 * i -: 8];
        end
        for (step = 0; step <= ROUNDS; step++) begin
            rd = (job.cmd == CMD_DEC) ? ROUNDS - step : step;
            if (step > 0) begin
                // Byte substitution and row shift; the inverse order is
                // irrelevant since both act bytewise on positions.
                for (int r = 0; r < 4; r++) begin
                    for (int c = 0; c < 4; c++) begin
                        if (job.cmd == CMD_DEC)
                            tmp[r + 4 * ((c + r) % 4)] = inv_sub[st[r + 4 * c]];
                        else
                            tmp[r + 4 * c] = fwd_sub[st[r + 4 * ((c + r) % 4)]];
                    end
                end
                st = tmp;
                // Encryption mixes columns before the key addition.
                if (job.cmd == CMD_ENC && step < ROUNDS) begin
                    mat = '{8'h02, 8'h03, 8'h01, 8'h01};
                    for (int c = 0; c < 4; c++) begin
                        for (int k = 0; k < 4; k++) col[k] = st[k + 4 * c];
                        for (int r = 0; r < 4; r++) begin
                            st[r + 4 * c] = 8'h00;
                            for (int k = 0; k < 4; k++)
                                st[r + 4 * c] ^= gf_times(mat[(k + 4 - r) % 4], col[k]);
                        end
                    end
                end
            end
            for (int c = 0; c < 4; c++) begin
                w = round_keys[rd * 4 + c];
                for (int r = 0; r < 4; r++) st[r + 4 * c] ^= w[31 - 8 * r -: 8];
            end
            // The inverse cipher mixes columns after the key addition.
            if (job.cmd == CMD_DEC && step > 0 && step < ROUNDS) begin
                mat = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
                for (int c = 0; c < 4; c++) begin
                    for (int k = 0; k < 4; k++) col[k] = st[k + 4 * c];
                    for (int r = 0; r < 4; r++) begin
                        st[r + 4 * c] = 8'h00;
                        for (int k = 0; k < 4; k++)
                            st[r + 4 * c] ^= gf_times(mat[(k + 4 - r) % 4], col[k]);
                    end
                end
            end
        end
        for (int i = 0; i < 8; i++) begin
            res.hi[63 - 8 * i -: 8] = st[i];
            res.lo[63 - 8 * i -: 8] = st[i + 8];
        end
        return res;
    endfunction

    // Driver: the beat on the bus is predicted as it is accepted, and the next
    // one is offered unless the sender idles this cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) cipher_expect_q.push_back(cipher_block(offered_job));
            if (!i_valid || o_ready) begin
                if (job_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered_job = job_queue.pop_front();
                    i_valid    <= 1'b1;
                    i_command  <= offered_job.cmd;
                    i_block_hi <= offered_job.hi;
                    i_block_lo <= offered_job.lo;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, or a solid hold-off while recv_hold is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: each output beat must match the oldest expected block.
    always @(posedge i_clk) begin
        cipher_text_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (cipher_expect_q.size() == 0) begin
                $error("output beat with no block expected: hi=%h lo=%h",
                       o_result_hi, o_result_lo);
                error_count++;
            end else begin
                want = cipher_expect_q.pop_front();
                if (o_result_hi !== want.hi) begin
                    $error("result_hi: expected %h, actual %h", want.hi, o_result_hi);
                    error_count++;
                end
                if (o_result_lo !== want.lo) begin
                    $error("result_lo: expected %h, actual %h", want.lo, o_result_lo);
                    error_count++;
                end
            end
        end
    end

    // Holds the receiver off for a number of cycles in a process of its own.
    task automatic hold_receiver(input int cycles);
        fork
            begin
                @(posedge i_clk);
                recv_hold <= 1'b1;
                repeat (cycles) @(posedge i_clk);
                recv_hold <= 1'b0;
            end
        join_none
    endtask

    task automatic queue_job(input logic cmd, input logic [63:0] hi, input logic [63:0] lo);
        cipher_job_t job;
        job.cmd = cmd;
        job.hi = hi;
        job.lo = lo;
        job_queue.push_back(job);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Waits until every queued beat went in and every result came out, then
    // lets the unit settle.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (job_queue.size() != 0 || i_valid || cipher_expect_q.size() != 0);
        repeat (ROUNDS + 4) @(posedge i_clk);
    endtask

    // Writes one key register; only called while the unit is idle or expanding a key.
    task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        key_reg[idx] = value;
        expand_schedule();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all_keys(input logic [63:0] k0, input logic [63:0] k1,
                                  input logic [63:0] k2, input logic [63:0] k3);
        write_key(CFG_KEY0, k0);
        write_key(CFG_KEY1, k1);
        write_key(CFG_KEY2, k2);
        write_key(CFG_KEY3, k3);
    endtask

    // A random phase: mostly fresh blocks, plus decrypts of ciphertext that
    // the model just produced so round trips are exercised too.
    task automatic random_phase(input int count);
        cipher_job_t  job;
        cipher_text_t ct;
        for (int n = 0; n < count; n++) begin
            job.cmd = $urandom_range(1) ? CMD_DEC : CMD_ENC;
            job.hi = rand64();
            job.lo = rand64();
            job_queue.push_back(job);
            if ($urandom_range(3) == 0 && job.cmd == CMD_ENC) begin
                ct = cipher_block(job);
                queue_job(CMD_DEC, ct.hi, ct.lo);
                n++;
            end
        end
    endtask

    initial begin
        build_sboxes();
        for (int i = 0; i < 4; i++) key_reg[i] = '0;
        expand_schedule();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first with the all-zero key that reset leaves behind.
        queue_job(CMD_ENC, '0, '0);
        queue_job(CMD_DEC, '0, '0);
        queue_job(CMD_ENC, '1, '1);
        queue_job(CMD_DEC, '1, '1);
        queue_job(CMD_ENC, 64'h8000000000000000, 64'h0000000000000001);
        wait_drained();

        // The standard example key and plaintext, both directions.
        write_all_keys(64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
        queue_job(CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
        queue_job(CMD_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        queue_job(CMD_ENC, '0, '1);
        queue_job(CMD_DEC, '1, '0);
        wait_drained();

        // All-ones key; the unused key registers 2 and 3 change without effect.
        write_all_keys('1, '1, 64'h0123456789abcdef, '0);
        queue_job(CMD_ENC, '0, '0);
        queue_job(CMD_DEC, '0, '0);
        queue_job(CMD_ENC, '1, '1);
        queue_job(CMD_DEC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        wait_drained();

        // Random phases, each with a fresh key and its own idling pattern.
        for (int ph = 0; ph < 4; ph++) begin
            write_all_keys(rand64(), rand64(), rand64(), rand64());
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 87;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 87;
                end
                default: begin
                    send_idle_pct = 29;
                    recv_stall_pct = 29;
                end
            endcase
            random_phase(170);
            // While the sender keeps offering beats, block the output long
            // enough for the unit to fill up and stall its input.
            if (ph == 0) hold_receiver(400);
            wait_drained();
        end

        // Back to the zero key to end on the other extreme.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_all_keys('0, '0, '0, '0);
        random_phase(20);
        wait_drained();

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
